@@ hdl/lcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpc_pkg: shared types and constants for the load-cell piece counter
// Field widths, datapath widths, opcode and status codes, reset values.
// ----------------------------------------------------------------------------
package lcpc_pkg;

  // beat field widths
  localparam int SAMPLE_W   = 24;
  localparam int KC_W       = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 8;
  localparam int EXACT_W    = 17;
  localparam int OFFSET_W   = 24;
  localparam int FACTOR_W   = 33;
  localparam int DEADBAND_W = 8;

  // averaging state
  localparam int SUM_W   = 28;
  localparam int TAKEN_W = 4;

  // shared divider operand widths
  localparam int DVD_W = 41;
  localparam int DVS_W = 33;

  // parameter defaults
  localparam int AVG_SAMPLES_DEF = 10;
  localparam int MAX_COUNT_DEF   = 255;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd77;
  localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 33'd256;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_TARE    = 2'd1,
    OP_CAL     = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MEASURED    = 3'd0,
    ST_TARE_AVG    = 3'd1,
    ST_TARE_APPLY  = 3'd2,
    ST_CAL_AVG     = 3'd3,
    ST_CAL_APPLY   = 3'd4,
    ST_CAL_REJECT  = 3'd5
  } status_t;

endpackage

@@ hdl/lcpc_if.sv @@
// ----------------------------------------------------------------------------
// lcpc_in_if / lcpc_out_if: valid/ready channels of the piece counter
// Sample beats in, result beats out.
// ----------------------------------------------------------------------------
interface lcpc_in_if;
  import lcpc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [KC_W-1:0]             known_count;

  modport source (output valid, opcode, sample, known_count, input ready);
  modport sink   (input valid, opcode, sample, known_count, output ready);
endinterface

interface lcpc_out_if;
  import lcpc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [COUNT_W-1:0]          count;
  logic signed [EXACT_W-1:0]   exact_count_q8;
  logic signed [OFFSET_W-1:0]  offset;
  logic signed [FACTOR_W-1:0]  factor_q8;

  modport source (output valid, status, count, exact_count_q8, offset, factor_q8,
                  input ready);
  modport sink   (input valid, status, count, exact_count_q8, offset, factor_q8,
                  output ready);
endinterface

@@ hdl/lcpc_div.sv @@
// ----------------------------------------------------------------------------
// lcpc_div: unsigned restoring divider, one quotient bit per cycle
// Operands latched on start; done pulses one cycle with quotient valid.
// ----------------------------------------------------------------------------
module lcpc_div #(
  parameter int DVD_W = lcpc_pkg::DVD_W,
  parameter int DVS_W = lcpc_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] sub;
  logic             ge;

  // shift next dividend bit into the partial remainder, try a subtract
  assign trial = {rem, quo[DVD_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, dvs};
  assign ge    = !sub[DVS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? sub[DVS_W-1:0] : trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/load_cell_piece_counter_top.sv @@
// ----------------------------------------------------------------------------
// load_cell_piece_counter_top: counting scale with tare and calibration
// Measure, tare apply and calibrate apply run through the 41-step shared
//   divider (calibrate apply twice); a measure with a zero factor and the
//   tare/cal averaging beats skip it. One sample beat at a time; ready drops until the
//   result is in the output register, which may still be waiting downstream.
// Reset (rst, synchronous): offset 0, factor 1.0 (256), count 0, averaging
//   cleared, deadband 77, output empty.
// ----------------------------------------------------------------------------
module load_cell_piece_counter_top #(
  parameter int AVG_SAMPLES = lcpc_pkg::AVG_SAMPLES_DEF,
  parameter int MAX_COUNT   = lcpc_pkg::MAX_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lcpc_pkg::DEADBAND_W-1:0]   cfg_wr_data,
  lcpc_in_if.sink                           samp,
  lcpc_out_if.source                        res
);
  import lcpc_pkg::*;

  // Sequencer: IDLE takes a beat. Measure, tare apply and calibrate apply
  // go through the shared divider; calibrate apply uses it twice (sum/N,
  // then (avg-offset)*256/known_count). PUT hands the result to the
  // output register as soon as it is free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MDIV,
    S_TDIV,
    S_CDIV1,
    S_CDIV2,
    S_PUT
  } state_t;

  state_t state;

  // architectural state
  logic [DEADBAND_W-1:0]      deadband;
  logic signed [OFFSET_W-1:0] tare_offset;
  logic signed [FACTOR_W-1:0] piece_factor;
  logic [COUNT_W-1:0]         stable_count;
  logic signed [SUM_W-1:0]    avg_sum;
  logic [TAKEN_W-1:0]         avg_taken;
  op_t                        run_mode;
  logic [KC_W-1:0]            run_known_count;

  // result staging and output register
  status_t                    res_status;
  logic signed [EXACT_W-1:0]  res_exact;
  logic                       out_valid;
  logic [STATUS_W-1:0]        out_status;
  logic [COUNT_W-1:0]         out_count;
  logic signed [EXACT_W-1:0]  out_exact;
  logic signed [OFFSET_W-1:0] out_offset;
  logic signed [FACTOR_W-1:0] out_factor;

  // divider hookup; q_neg carries the sign of the pending quotient
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic             q_neg;

  lcpc_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- accept-side decode ----------------
  logic                      accept;
  op_t                       op_eff;
  logic                      mode_chg;
  logic signed [SUM_W-1:0]   sum_base;
  logic signed [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]          sum_mag;
  logic [TAKEN_W-1:0]        taken_base;
  logic [TAKEN_W-1:0]        taken_new;
  logic                      run_done;
  logic [KC_W-1:0]           kc_eff;

  assign accept   = samp.valid && samp.ready;
  // opcode three behaves as measure
  assign op_eff   = (samp.opcode == OP_RSVD) ? OP_MEASURE : op_t'(samp.opcode);
  // any change of effective opcode restarts averaging
  assign mode_chg   = (op_eff != run_mode);
  assign sum_base   = mode_chg ? '0 : avg_sum;
  assign taken_base = mode_chg ? '0 : avg_taken;
  assign sum_new    = sum_base + SUM_W'(samp.sample);
  assign taken_new  = taken_base + TAKEN_W'(1);
  assign run_done   = (taken_new >= TAKEN_W'(AVG_SAMPLES));
  assign sum_mag    = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
  // known count comes from the first beat of a calibrate run
  assign kc_eff     = (taken_base == '0) ? samp.known_count : run_known_count;

  // measure operands: (sample - offset) << 16 over |factor|
  logic signed [OFFSET_W:0]   m_diff;
  logic [DVD_W-1:0]           m_num;
  logic [DVD_W-1:0]           m_mag;
  logic [FACTOR_W-1:0]        f_mag;

  assign m_diff = (OFFSET_W+1)'(samp.sample) - (OFFSET_W+1)'(tare_offset);
  assign m_num  = {m_diff, 16'h0000};
  assign m_mag  = m_num[DVD_W-1] ? (~m_num + DVD_W'(1)) : m_num;
  assign f_mag  = piece_factor[FACTOR_W-1] ? (~piece_factor + FACTOR_W'(1))
                                           : piece_factor;

  // ---------------- divider-result side ----------------
  // measure: round half away from zero on the magnitude, deadband check
  logic [7:0]          m_frac;
  logic [DVD_W-9:0]    m_whole;
  logic [DVD_W-8:0]    m_rmag;
  logic [8:0]          m_dist;
  logic                m_take;
  logic                m_negx;
  logic [COUNT_W-1:0]  m_count;
  logic [EXACT_W-1:0]  m_exact;

  assign m_frac  = div_quo[7:0];
  assign m_whole = div_quo[DVD_W-1:8];
  assign m_rmag  = (DVD_W-7)'(m_whole) + (DVD_W-7)'(m_frac[7]);
  assign m_dist  = m_frac[7] ? (9'd256 - 9'(m_frac)) : 9'(m_frac);
  assign m_take  = (m_dist < 9'(deadband));
  assign m_negx  = q_neg && (div_quo != '0);

  always_comb begin
    if (m_negx || (m_rmag == '0)) begin
      m_count = '0;
    end else if (m_rmag > (DVD_W-7)'(MAX_COUNT)) begin
      m_count = COUNT_W'(MAX_COUNT);
    end else begin
      m_count = m_rmag[COUNT_W-1:0];
    end
  end

  // reported value saturates to the 17-bit signed range
  always_comb begin
    if (m_negx) begin
      if (div_quo > DVD_W'(65536)) begin
        m_exact = 17'h10000;
      end else begin
        m_exact = ~div_quo[EXACT_W-1:0] + EXACT_W'(1);
      end
    end else if (div_quo > DVD_W'(65535)) begin
      m_exact = 17'h0FFFF;
    end else begin
      m_exact = div_quo[EXACT_W-1:0];
    end
  end

  // tare apply: signed average
  logic [OFFSET_W-1:0] t_avg;
  assign t_avg = q_neg ? (~div_quo[OFFSET_W-1:0] + OFFSET_W'(1))
                       : div_quo[OFFSET_W-1:0];

  // calibrate, first pass done: average, minus offset, times 256
  logic signed [OFFSET_W:0]   c_avg;
  logic signed [OFFSET_W+1:0] c_diff;
  logic [OFFSET_W+1:0]        c_mag;

  assign c_avg  = q_neg ? (~div_quo[OFFSET_W:0] + (OFFSET_W+1)'(1))
                        : div_quo[OFFSET_W:0];
  assign c_diff = (OFFSET_W+2)'(c_avg) - (OFFSET_W+2)'(tare_offset);
  assign c_mag  = c_diff[OFFSET_W+1] ? (~c_diff + (OFFSET_W+2)'(1)) : c_diff;

  // calibrate, second pass done: new factor
  logic [FACTOR_W-1:0] c_factor;
  assign c_factor = q_neg ? (~div_quo[FACTOR_W-1:0] + FACTOR_W'(1))
                          : div_quo[FACTOR_W-1:0];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      deadband        <= DEADBAND_RST;
      tare_offset     <= '0;
      piece_factor    <= FACTOR_RST;
      stable_count    <= '0;
      avg_sum         <= '0;
      avg_taken       <= '0;
      run_mode        <= OP_MEASURE;
      run_known_count <= '0;
      out_valid       <= 1'b0;
      div_start       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_wr_en) begin
        deadband <= cfg_wr_data;
      end
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            run_mode  <= op_eff;
            res_exact <= '0;
            case (op_eff)
              OP_TARE: begin
                if (run_done) begin
                  avg_sum   <= '0;
                  avg_taken <= '0;
                  div_dvd   <= DVD_W'(sum_mag);
                  div_dvs   <= DVS_W'(AVG_SAMPLES);
                  q_neg     <= sum_new[SUM_W-1];
                  div_start <= 1'b1;
                  state     <= S_TDIV;
                end else begin
                  avg_sum    <= sum_new;
                  avg_taken  <= taken_new;
                  res_status <= ST_TARE_AVG;
                  state      <= S_PUT;
                end
              end
              OP_CAL: begin
                run_known_count <= kc_eff;
                if (kc_eff == '0) begin
                  avg_sum    <= sum_base;
                  avg_taken  <= taken_base;
                  res_status <= ST_CAL_REJECT;
                  state      <= S_PUT;
                end else if (run_done) begin
                  avg_sum   <= '0;
                  avg_taken <= '0;
                  div_dvd   <= DVD_W'(sum_mag);
                  div_dvs   <= DVS_W'(AVG_SAMPLES);
                  q_neg     <= sum_new[SUM_W-1];
                  div_start <= 1'b1;
                  state     <= S_CDIV1;
                end else begin
                  avg_sum    <= sum_new;
                  avg_taken  <= taken_new;
                  res_status <= ST_CAL_AVG;
                  state      <= S_PUT;
                end
              end
              default: begin
                // measure
                avg_sum    <= sum_base;
                avg_taken  <= taken_base;
                res_status <= ST_MEASURED;
                if (piece_factor == '0) begin
                  state <= S_PUT;
                end else begin
                  div_dvd   <= m_mag;
                  div_dvs   <= DVS_W'(f_mag);
                  q_neg     <= m_diff[OFFSET_W] ^ piece_factor[FACTOR_W-1];
                  div_start <= 1'b1;
                  state     <= S_MDIV;
                end
              end
            endcase
          end
        end

        S_MDIV: begin
          if (div_done) begin
            if (m_take) begin
              stable_count <= m_count;
            end
            res_exact <= m_exact;
            state     <= S_PUT;
          end
        end

        S_TDIV: begin
          if (div_done) begin
            tare_offset <= t_avg;
            res_status  <= ST_TARE_APPLY;
            state       <= S_PUT;
          end
        end

        S_CDIV1: begin
          if (div_done) begin
            div_dvd   <= DVD_W'({c_mag, 8'h00});
            div_dvs   <= DVS_W'(run_known_count);
            q_neg     <= c_diff[OFFSET_W+1];
            div_start <= 1'b1;
            state     <= S_CDIV2;
          end
        end

        S_CDIV2: begin
          if (div_done) begin
            piece_factor <= c_factor;
            res_status   <= ST_CAL_APPLY;
            state        <= S_PUT;
          end
        end

        S_PUT: begin
          // load the output register once its last beat has gone
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= stable_count;
            out_exact  <= res_exact;
            out_offset <= tare_offset;
            out_factor <= piece_factor;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign samp.ready         = (state == S_IDLE);
  assign res.valid          = out_valid;
  assign res.status         = out_status;
  assign res.count          = out_count;
  assign res.exact_count_q8 = out_exact;
  assign res.offset         = out_offset;
  assign res.factor_q8      = out_factor;

endmodule

@@ hdl/lcpc_checker.sv @@
// ----------------------------------------------------------------------------
// lcpc_checker: port-level assertions for the piece counter top level
// Bound to load_cell_piece_counter_top below.
// ----------------------------------------------------------------------------
module lcpc_checker #(
  parameter int MAX_COUNT = lcpc_pkg::MAX_COUNT_DEF
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [lcpc_pkg::STATUS_W-1:0]          status,
  input logic [lcpc_pkg::COUNT_W-1:0]           count,
  input logic signed [lcpc_pkg::EXACT_W-1:0]    exact_count_q8
);
  import lcpc_pkg::*;

  // one sample in flight: ready drops right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous beat still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
    else $error("result beat changed while stalled");

  // only measure results carry an exact count
  a_exact_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_MEASURED) |-> exact_count_q8 == '0)
    else $error("non-measure result with nonzero exact count");

  // count never exceeds the clamp
  a_count_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(count) <= MAX_COUNT)
    else $error("count above clamp");

endmodule

bind load_cell_piece_counter_top lcpc_checker #(
  .MAX_COUNT (MAX_COUNT)
) u_lcpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samp.valid),
  .in_ready       (samp.ready),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .status         (res.status),
  .count          (res.count),
  .exact_count_q8 (res.exact_count_q8)
);
